// ===== rtl/cau_pkg.sv =====
// ============================================================================
// cau_pkg
// Shared types, codes and saturation helpers of the complex arithmetic unit.
// ============================================================================
package cau_pkg;

	localparam int NumStages = 21;
	localparam int DivStages = 17;

	localparam logic [1:0] CmdAdd = 2'd0;
	localparam logic [1:0] CmdSub = 2'd1;
	localparam logic [1:0] CmdMul = 2'd2;
	localparam logic [1:0] CmdDiv = 2'd3;

	localparam logic [1:0] StatOk      = 2'd0;
	localparam logic [1:0] StatSat     = 2'd1;
	localparam logic [1:0] StatDivZero = 2'd2;

	localparam logic [15:0] QMax = 16'h7fff;
	localparam logic [15:0] QMin = 16'h8000;

	typedef struct packed {
		logic        is_div;
		logic        zero;
		logic        dsat;
		logic [15:0] res_re;
		logic [15:0] res_im;
		logic        neg_re;
		logic        neg_im;
		logic        ovf_re;
		logic        ovf_im;
		logic [39:0] rem_re;
		logic [39:0] rem_im;
		logic [16:0] q_re;
		logic [16:0] q_im;
		logic [47:0] dsh;
	} div_t;

	// {saturated, value}
	function automatic logic [16:0] clamp_q(input logic signed [24:0] v);
		if (v > 25'sd32767) begin
			return {1'b1, QMax};
		end
		if (v < -25'sd32768) begin
			return {1'b1, QMin};
		end
		return {1'b0, v[15:0]};
	endfunction

	// {saturated, value} from quotient magnitude and sign
	function automatic logic [16:0] div_fix(input logic neg, input logic ovf,
		input logic [16:0] q);
		logic [16:0] nq;
		nq = -q;
		if (ovf) begin
			return {1'b1, neg ? QMin : QMax};
		end
		if (neg) begin
			if (q > 17'd32768) begin
				return {1'b1, QMin};
			end
			return {1'b0, nq[15:0]};
		end
		if (q > 17'd32767) begin
			return {1'b1, QMax};
		end
		return {1'b0, q[15:0]};
	endfunction

endpackage

// ===== rtl/cau_front.sv =====
// ============================================================================
// cau_front
// Products, sums and divider setup: three pipeline stages.
// ============================================================================
module cau_front (
	input  logic               clk,
	input  logic [2:0]         en,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] ar,
	input  logic signed [15:0] ai,
	input  logic signed [15:0] br,
	input  logic signed [15:0] bi,
	output cau_pkg::div_t      out_s3
);

	logic signed [31:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_br2_s1, p_bi2_s1;
	logic signed [16:0] sum_re_s1, sum_im_s1;
	logic [1:0]         cmd_s1;

	logic signed [32:0] mre_s2, mim_s2, nre_s2, nim_s2;
	logic [31:0]        d_s2;
	logic signed [16:0] sum_re_s2, sum_im_s2;
	logic [1:0]         cmd_s2;

	logic signed [24:0] dir_re, dir_im;
	logic [16:0]        cl_re, cl_im;
	logic [32:0]        abs_re, abs_im;
	logic [39:0]        mag_re, mag_im;
	cau_pkg::div_t      nxt;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_rr_s1  <= ar * br;
			p_ii_s1  <= ai * bi;
			p_ri_s1  <= ar * bi;
			p_ir_s1  <= ai * br;
			p_br2_s1 <= br * br;
			p_bi2_s1 <= bi * bi;
			sum_re_s1 <= (cmd == cau_pkg::CmdSub) ? (17'(ar) - 17'(br)) : (17'(ar) + 17'(br));
			sum_im_s1 <= (cmd == cau_pkg::CmdSub) ? (17'(ai) - 17'(bi)) : (17'(ai) + 17'(bi));
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mre_s2 <= 33'(p_rr_s1) - 33'(p_ii_s1);
			mim_s2 <= 33'(p_ri_s1) + 33'(p_ir_s1);
			nre_s2 <= 33'(p_rr_s1) + 33'(p_ii_s1);
			nim_s2 <= 33'(p_ir_s1) - 33'(p_ri_s1);
			d_s2   <= $unsigned(p_br2_s1) + $unsigned(p_bi2_s1);
			sum_re_s2 <= sum_re_s1;
			sum_im_s2 <= sum_im_s1;
			cmd_s2 <= cmd_s1;
		end
	end

	always_comb begin
		dir_re = (cmd_s2 == cau_pkg::CmdMul) ? $signed(mre_s2[32:8]) : 25'(sum_re_s2);
		dir_im = (cmd_s2 == cau_pkg::CmdMul) ? $signed(mim_s2[32:8]) : 25'(sum_im_s2);
		cl_re  = cau_pkg::clamp_q(dir_re);
		cl_im  = cau_pkg::clamp_q(dir_im);
		abs_re = nre_s2[32] ? $unsigned(-nre_s2) : $unsigned(nre_s2);
		abs_im = nim_s2[32] ? $unsigned(-nim_s2) : $unsigned(nim_s2);
		mag_re = {abs_re[31:0], 8'd0};
		mag_im = {abs_im[31:0], 8'd0};
		nxt.is_div = (cmd_s2 == cau_pkg::CmdDiv);
		nxt.zero   = (d_s2 == 32'd0);
		nxt.dsat   = cl_re[16] | cl_im[16];
		nxt.res_re = cl_re[15:0];
		nxt.res_im = cl_im[15:0];
		nxt.neg_re = nre_s2[32];
		nxt.neg_im = nim_s2[32];
		nxt.ovf_re = ({9'd0, mag_re} >= {d_s2, 17'd0});
		nxt.ovf_im = ({9'd0, mag_im} >= {d_s2, 17'd0});
		nxt.rem_re = mag_re;
		nxt.rem_im = mag_im;
		nxt.q_re   = '0;
		nxt.q_im   = '0;
		nxt.dsh    = {d_s2, 16'd0};
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			out_s3 <= nxt;
		end
	end

endmodule

// ===== rtl/cau_div_stage.sv =====
// ============================================================================
// cau_div_stage
// One restoring division step for both result parts, one quotient bit each.
// ============================================================================
module cau_div_stage (
	input  logic          clk,
	input  logic          en,
	input  cau_pkg::div_t in_s,
	output cau_pkg::div_t out_s
);

	logic          ge_re, ge_im;
	cau_pkg::div_t nxt;

	always_comb begin
		nxt   = in_s;
		ge_re = ({8'd0, in_s.rem_re} >= in_s.dsh);
		ge_im = ({8'd0, in_s.rem_im} >= in_s.dsh);
		if (ge_re) begin
			nxt.rem_re = in_s.rem_re - in_s.dsh[39:0];
		end
		if (ge_im) begin
			nxt.rem_im = in_s.rem_im - in_s.dsh[39:0];
		end
		nxt.q_re = {in_s.q_re[15:0], ge_re};
		nxt.q_im = {in_s.q_im[15:0], ge_im};
		nxt.dsh  = {1'b0, in_s.dsh[47:1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s <= nxt;
		end
	end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// ============================================================================
// complex_arithmetic_unit
// Q8.8 complex add, subtract, multiply and divide with saturation.
// Pipeline: 3 front stages, 17 divider bit stages and 1 output stage from input
//   transaction to result; every command takes the same path.
// Throughput: one transaction per cycle; each stage holds under backpressure.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
// ============================================================================
module complex_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // command, a_real, a_imag, b_real, b_imag
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // res_real, res_imag, status
);

	localparam int N = cau_pkg::NumStages;
	localparam int D = cau_pkg::DivStages;

	logic [N:0]    en;
	logic [N-1:0]  valid_q;
	cau_pkg::div_t chain [D+1];
	cau_pkg::div_t fin;
	logic [16:0]   fx_re, fx_im;
	logic [15:0]   res_real_s21, res_imag_s21;
	logic [1:0]    status_s21;

	always_comb begin
		en[N] = m_axis_tready;
		for (int i = N - 1; i >= 0; i--) begin
			en[i] = !valid_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < N; i++) begin
				if (en[i]) begin
					valid_q[i] <= (i == 0) ? s_axis_tvalid : valid_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	cau_front u_front (
		.clk    (clk),
		.en     (en[2:0]),
		.cmd    (s_axis_tdata[1:0]),
		.ar     ($signed(s_axis_tdata[17:2])),
		.ai     ($signed(s_axis_tdata[33:18])),
		.br     ($signed(s_axis_tdata[49:34])),
		.bi     ($signed(s_axis_tdata[65:50])),
		.out_s3 (chain[0])
	);

	for (genvar k = 0; k < D; k++) begin : g_div
		cau_div_stage u_stage (
			.clk   (clk),
			.en    (en[3+k]),
			.in_s  (chain[k]),
			.out_s (chain[k+1])
		);
	end

	always_comb begin
		fin   = chain[D];
		fx_re = cau_pkg::div_fix(fin.neg_re, fin.ovf_re, fin.q_re);
		fx_im = cau_pkg::div_fix(fin.neg_im, fin.ovf_im, fin.q_im);
	end

	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			if (!fin.is_div) begin
				res_real_s21 <= fin.res_re;
				res_imag_s21 <= fin.res_im;
				status_s21   <= fin.dsat ? cau_pkg::StatSat : cau_pkg::StatOk;
			end else if (fin.zero) begin
				res_real_s21 <= '0;
				res_imag_s21 <= '0;
				status_s21   <= cau_pkg::StatDivZero;
			end else begin
				res_real_s21 <= fx_re[15:0];
				res_imag_s21 <= fx_im[15:0];
				status_s21   <= (fx_re[16] | fx_im[16]) ? cau_pkg::StatSat : cau_pkg::StatOk;
			end
		end
	end

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = valid_q[N-1];
	assign m_axis_tdata  = {6'd0, status_s21, res_imag_s21, res_real_s21};

endmodule

// ===== rtl/cau_checker.sv =====
// ============================================================================
// cau_port_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ============================================================================
module cau_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [71:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	logic [15:0] c_re, c_im;
	logic [1:0]  c_st;

	assign c_re = m_axis_tdata[15:0];
	assign c_im = m_axis_tdata[31:16];
	assign c_st = m_axis_tdata[33:32];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (c_st == cau_pkg::StatOk || c_st == cau_pkg::StatSat ||
			c_st == cau_pkg::StatDivZero))
		else $error("undefined status");

	a_divzero_parts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && c_st == cau_pkg::StatDivZero |-> c_re == 16'd0 && c_im == 16'd0)
		else $error("zero divisor result not zero");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && c_st == cau_pkg::StatSat |->
			(c_re == cau_pkg::QMax || c_re == cau_pkg::QMin ||
			 c_im == cau_pkg::QMax || c_im == cau_pkg::QMin))
		else $error("saturation status without a clamped part");

endmodule

bind complex_arithmetic_unit cau_port_checker u_cau_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
